@@ rtl/conv2d_valid_strided_assert.svh @@
// Assertion macros for the strided convolution block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef CONV2D_VALID_STRIDED_ASSERT_SVH
`define CONV2D_VALID_STRIDED_ASSERT_SVH

// same-cycle implication
`define CVS_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");

// next-cycle implication
`define CVS_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/cvs_pkg.sv @@
// Package for the strided convolution block: sizes, register codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cvs_pkg;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_KROWS    = 7;
    localparam int MAX_KCOLS    = 7;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_KERNELS  = 16;
    localparam int MAX_STRIDE   = 7;
    localparam int W_DEPTH = MAX_KERNELS * MAX_KROWS * MAX_KCOLS * MAX_CHANNELS;
    localparam int L_DEPTH = MAX_KROWS * MAX_WIDTH * MAX_CHANNELS;
    localparam int W_AW = 13;
    localparam int L_AW = 14;
    localparam int KSTEP = MAX_KROWS * MAX_KCOLS;

    // configuration register indexes
    localparam logic [3:0] REG_WIDTH   = 4'd0;
    localparam logic [3:0] REG_HEIGHT  = 4'd1;
    localparam logic [3:0] REG_KROWS   = 4'd2;
    localparam logic [3:0] REG_KCOLS   = 4'd3;
    localparam logic [3:0] REG_CHANS   = 4'd4;
    localparam logic [3:0] REG_KERNELS = 4'd5;
    localparam logic [3:0] REG_STRIDE  = 4'd6;
    localparam logic [3:0] REG_BIAS    = 4'd7;

    // transaction kinds
    localparam logic [1:0] FUNC_WEIGHT = 2'd0;
    localparam logic [1:0] FUNC_BIAS   = 2'd1;
    localparam logic [1:0] FUNC_PIXEL  = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_OUT} state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // zero counts as one, larger values saturate
    function automatic logic [12:0] clamp_reg(input logic [12:0] v, input logic [12:0] mx);
        logic [12:0] r;
        begin
            r = v;
            if (r == 13'd0)
                r = 13'd1;
            if (r > mx)
                r = mx;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/cvs_ram.sv @@
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cvs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/cvs_mac.sv @@
// Shared multiply-accumulate unit: product stage, accumulate, bias and saturate.
// Depends on cvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cvs_mac (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cvs_pkg::mac_ctl_t    ctl,
    input  wire logic signed [15:0]   px,
    input  wire logic signed [15:0]   wt,
    input  wire logic signed [23:0]   bias_term,
    output logic                      done,
    output logic             [39:0]   sum
);
    import cvs_pkg::*;

    mac_ctl_t           p_ctl_reg;
    logic signed [31:0] prod_reg;
    logic signed [41:0] acc_reg, acc_next;
    logic               fin_reg;
    logic signed [41:0] tot;
    logic               done_reg;
    logic        [39:0] sum_reg;

    // control pipeline alongside the product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg <= '0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            p_ctl_reg <= ctl;
            fin_reg   <= p_ctl_reg.valid & p_ctl_reg.last;
            done_reg  <= fin_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (p_ctl_reg.valid)
            acc_next = p_ctl_reg.first ? 42'(prod_reg) : acc_reg + 42'(prod_reg);
        tot = acc_reg + 42'(bias_term);
    end

    // product, accumulate, then bias and saturate
    always_ff @(posedge clk)
    begin
        prod_reg <= px * wt;
        acc_reg  <= acc_next;
        if (tot > 42'sd549755813887)
            sum_reg <= 40'h7F_FFFF_FFFF;
        else if (tot < -42'sd549755813888)
            sum_reg <= 40'h80_0000_0000;
        else
            sum_reg <= tot[39:0];
    end

    assign done = done_reg;
    assign sum  = sum_reg;
endmodule
`default_nettype wire

@@ rtl/conv2d_valid_strided.sv @@
// A completing sample starts kernel 0: the shared MAC takes every window product, and
// the sum is offered once the MAC is done; each further kernel starts after the
// previous result is taken. Loads and non-completing samples pass back to back while
// idle; a completing sample holds the input until the last kernel's result is taken.
// Reset: asynchronous active low; registers return to 256,256,3,3,1,1,1,0 and the
// position to zero. Weight, bias and line stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_strided_assert.svh"
module conv2d_valid_strided (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // weight_index[12:0], sample_value[28:13], zero pad
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // sum_value[39:0], kernel_id[43:40],
                                        // out_row[55:44], out_col[63:56]
    output logic             m_tlast    // last
);
    import cvs_pkg::*;

    // configuration (clamped on write)
    logic [8:0] w_reg;
    logic [12:0] h_reg;
    logic [2:0] kr_reg, kc_reg, s_reg;
    logic [3:0] c_reg;
    logic [4:0] k_reg;
    logic       b_reg;

    // stream position
    logic [11:0] r_reg, r_next;
    logic [7:0]  c_pos_reg, c_pos_next;
    logic [2:0]  ch_reg, ch_next;
    logic [2:0]  rslot_reg, rslot_next;
    logic [2:0]  rph_reg, rph_next, cph_reg, cph_next;
    logic [11:0] orow_reg, orow_next;
    logic [7:0]  ocol_reg, ocol_next;

    // window sequencer
    state_t      st_reg, st_next;
    logic [2:0]  tslot_reg, tslot_next, rs_reg, rs_next;
    logic [7:0]  left_reg, left_next;
    logic [11:0] wrow_reg, wrow_next;
    logic [7:0]  wcol_reg, wcol_next;
    logic [3:0]  kk_reg, kk_next;
    logic [2:0]  ii_reg, ii_next, jj_reg, jj_next, qq_reg, qq_next;
    logic [9:0]  kbase_reg, kbase_next, wpix_reg, wpix_next;
    mac_ctl_t    ctl_reg, ctl_next;
    logic        ovalid_reg, ovalid_next;
    logic [39:0] osum_reg;

    logic signed [15:0] bias_mem [MAX_KERNELS];

    logic        acc_in;
    logic [1:0]  func;
    logic [12:0] widx;
    logic [15:0] sval;
    logic        win;
    logic [3:0]  tsum;
    logic [2:0]  tslot_calc;
    logic        w_we, l_we;
    logic [W_AW-1:0] w_raddr;
    logic [L_AW-1:0] l_waddr, l_raddr;
    logic [15:0] w_rdata, l_rdata;
    logic        mac_done;
    logic [39:0] mac_sum;
    logic signed [23:0] bias_term;
    logic        geo_wr;

    assign func   = s_tuser;
    assign widx   = s_tdata[12:0];
    assign sval   = s_tdata[28:13];
    assign s_tready = (st_reg == ST_IDLE);
    assign acc_in = s_tvalid & s_tready;
    assign geo_wr = cfg_we & (cfg_index <= REG_STRIDE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 9'd256;
            h_reg  <= 13'd256;
            kr_reg <= 3'd3;
            kc_reg <= 3'd3;
            c_reg  <= 4'd1;
            k_reg  <= 5'd1;
            s_reg  <= 3'd1;
            b_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:   w_reg  <= 9'(clamp_reg({4'd0, cfg_data[8:0]}, 13'(MAX_WIDTH)));
                REG_HEIGHT:  h_reg  <= clamp_reg(cfg_data, 13'(MAX_HEIGHT));
                REG_KROWS:   kr_reg <= 3'(clamp_reg({10'd0, cfg_data[2:0]}, 13'(MAX_KROWS)));
                REG_KCOLS:   kc_reg <= 3'(clamp_reg({10'd0, cfg_data[2:0]}, 13'(MAX_KCOLS)));
                REG_CHANS:   c_reg  <= 4'(clamp_reg({9'd0, cfg_data[3:0]}, 13'(MAX_CHANNELS)));
                REG_KERNELS: k_reg  <= 5'(clamp_reg({8'd0, cfg_data[4:0]}, 13'(MAX_KERNELS)));
                REG_STRIDE:  s_reg  <= 3'(clamp_reg({10'd0, cfg_data[2:0]}, 13'(MAX_STRIDE)));
                REG_BIAS:    b_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // window test on the incoming sample
    assign win = (ch_reg == 3'(c_reg - 4'd1)) && ({1'b0, r_reg} + 13'd1 >= 13'(kr_reg))
               && ({1'b0, c_pos_reg} + 9'd1 >= 9'(kc_reg)) && (rph_reg == 3'd0)
               && (cph_reg == 3'd0);
    assign tsum = 4'(rslot_reg) + 4'd8 - 4'(kr_reg);
    assign tslot_calc = (tsum >= 4'd7) ? 3'(tsum - 4'd7) : tsum[2:0];

    // position tracking, cleared on a geometry write, advanced on every pixel transaction
    always_comb
    begin
        r_next = r_reg; c_pos_next = c_pos_reg; ch_next = ch_reg; rslot_next = rslot_reg;
        rph_next = rph_reg; cph_next = cph_reg; orow_next = orow_reg; ocol_next = ocol_reg;
        if (geo_wr)
        begin
            r_next = '0; c_pos_next = '0; ch_next = '0; rslot_next = '0;
            rph_next = '0; cph_next = '0; orow_next = '0; ocol_next = '0;
        end
        else if (acc_in && func == FUNC_PIXEL)
        begin
            if (ch_reg == 3'(c_reg - 4'd1))
            begin
                ch_next = '0;
                if ({1'b0, c_pos_reg} == w_reg - 9'd1)
                begin
                    c_pos_next = '0;
                    cph_next = '0;
                    ocol_next = '0;
                    if ({1'b0, r_reg} == h_reg - 13'd1)
                    begin
                        r_next = '0;
                        rslot_next = '0;
                    end
                    else
                    begin
                        r_next = r_reg + 12'd1;
                        rslot_next = (rslot_reg == 3'(MAX_KROWS - 1)) ? 3'd0 : rslot_reg + 3'd1;
                    end
                    if ({1'b0, r_next} + 13'd1 > 13'(kr_reg))
                    begin
                        if (rph_reg == s_reg - 3'd1)
                        begin
                            rph_next = '0;
                            orow_next = orow_reg + 12'd1;
                        end
                        else
                            rph_next = rph_reg + 3'd1;
                    end
                    else
                    begin
                        rph_next = '0;
                        orow_next = '0;
                    end
                end
                else
                begin
                    c_pos_next = c_pos_reg + 8'd1;
                    if ({1'b0, c_pos_next} + 9'd1 > 9'(kc_reg))
                    begin
                        if (cph_reg == s_reg - 3'd1)
                        begin
                            cph_next = '0;
                            ocol_next = ocol_reg + 8'd1;
                        end
                        else
                            cph_next = cph_reg + 3'd1;
                    end
                    else
                    begin
                        cph_next = '0;
                        ocol_next = '0;
                    end
                end
            end
            else
                ch_next = ch_reg + 3'd1;
        end
    end

    // sequencer: next state and read addressing
    always_comb
    begin
        st_next = st_reg; tslot_next = tslot_reg; rs_next = rs_reg; left_next = left_reg;
        wrow_next = wrow_reg; wcol_next = wcol_reg; kk_next = kk_reg; ii_next = ii_reg;
        jj_next = jj_reg; qq_next = qq_reg; kbase_next = kbase_reg; wpix_next = wpix_reg;
        ctl_next = '0; ovalid_next = ovalid_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (acc_in && func == FUNC_PIXEL && win)
                begin
                    st_next = ST_RUN;
                    tslot_next = tslot_calc;
                    rs_next = tslot_calc;
                    left_next = c_pos_reg - 8'(kc_reg - 3'd1);
                    wrow_next = orow_reg;
                    wcol_next = ocol_reg;
                    kk_next = '0; ii_next = '0; jj_next = '0; qq_next = '0;
                    kbase_next = '0; wpix_next = '0;
                end
            end
            ST_RUN:
            begin
                ctl_next.valid = 1'b1;
                ctl_next.first = (ii_reg == 3'd0) && (jj_reg == 3'd0) && (qq_reg == 3'd0);
                ctl_next.last = 1'b0;
                if (qq_reg == 3'(c_reg - 4'd1))
                begin
                    qq_next = '0;
                    if (jj_reg == kc_reg - 3'd1)
                    begin
                        jj_next = '0;
                        wpix_next = wpix_reg + 10'(4'd8 - 4'(kc_reg));
                        rs_next = (rs_reg == 3'(MAX_KROWS - 1)) ? 3'd0 : rs_reg + 3'd1;
                        if (ii_reg == kr_reg - 3'd1)
                        begin
                            ii_next = '0;
                            ctl_next.last = 1'b1;
                            st_next = ST_WAIT;
                        end
                        else
                            ii_next = ii_reg + 3'd1;
                    end
                    else
                    begin
                        jj_next = jj_reg + 3'd1;
                        wpix_next = wpix_reg + 10'd1;
                    end
                end
                else
                    qq_next = qq_reg + 3'd1;
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    st_next = ST_OUT;
                    ovalid_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    if ({1'b0, kk_reg} == k_reg - 5'd1)
                        st_next = ST_IDLE;
                    else
                    begin
                        st_next = ST_RUN;
                        kk_next = kk_reg + 4'd1;
                        kbase_next = kbase_reg + 10'(KSTEP);
                        wpix_next = kbase_reg + 10'(KSTEP);
                        rs_next = tslot_reg;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ctl_reg <= '0;
            ovalid_reg <= 1'b0;
            r_reg <= '0; c_pos_reg <= '0; ch_reg <= '0; rslot_reg <= '0;
            rph_reg <= '0; cph_reg <= '0; orow_reg <= '0; ocol_reg <= '0;
            kk_reg <= '0; ii_reg <= '0; jj_reg <= '0; qq_reg <= '0;
            kbase_reg <= '0; wpix_reg <= '0; rs_reg <= '0; tslot_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ctl_reg <= ctl_next;
            ovalid_reg <= ovalid_next;
            r_reg <= r_next; c_pos_reg <= c_pos_next; ch_reg <= ch_next;
            rslot_reg <= rslot_next;
            rph_reg <= rph_next; cph_reg <= cph_next;
            orow_reg <= orow_next; ocol_reg <= ocol_next;
            kk_reg <= kk_next; ii_reg <= ii_next; jj_reg <= jj_next; qq_reg <= qq_next;
            kbase_reg <= kbase_next; wpix_reg <= wpix_next;
            rs_reg <= rs_next; tslot_reg <= tslot_next;
        end
    end

    // window payload and bias store
    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        wrow_reg <= wrow_next;
        wcol_reg <= wcol_next;
        if (st_reg == ST_WAIT && mac_done)
            osum_reg <= mac_sum;
        if (acc_in && func == FUNC_BIAS && widx < 13'(MAX_KERNELS))
            bias_mem[widx[3:0]] <= sval;
    end

    assign bias_term = b_reg ? {bias_mem[kk_reg], 8'd0} : 24'sd0;

    // memories
    assign w_we    = acc_in && func == FUNC_WEIGHT && widx < 13'(W_DEPTH);
    assign w_raddr = {wpix_reg, qq_reg};
    assign l_we    = acc_in && func == FUNC_PIXEL;
    assign l_waddr = {rslot_reg, c_pos_reg, ch_reg};
    assign l_raddr = {rs_reg, 8'(left_reg + 8'(jj_reg)), qq_reg};

    cvs_ram #(.DEPTH(W_DEPTH), .WIDTH(16), .AW(W_AW)) u_wram (
        .clk(clk), .we(w_we), .waddr(widx), .wdata(sval),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    cvs_ram #(.DEPTH(L_DEPTH), .WIDTH(16), .AW(L_AW)) u_lram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(sval),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    cvs_mac u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_reg),
        .px(l_rdata), .wt(w_rdata), .bias_term(bias_term),
        .done(mac_done), .sum(mac_sum)
    );

    // result port
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {wcol_reg, wrow_reg, kk_reg, osum_reg};
    assign m_tlast  = ({1'b0, kk_reg} == k_reg - 5'd1);

    `CVS_ASSERT_IMP(a_ready_excl, s_tready, !m_tvalid)
    `CVS_ASSERT_IMP(a_done_in_wait, mac_done, st_reg == ST_WAIT)
    `CVS_ASSERT_NXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready)
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the strided multi-channel 2-D convolution block.
// Depends on cvs_pkg and conv2d_valid_strided; predicts every window sum and checks each one.
`timescale 1ns / 1ps
module testbench;
    import cvs_pkg::*;

    typedef struct packed {
        logic [39:0] sum_value;
        logic [3:0]  kernel_id;
        logic [11:0] out_row;
        logic [7:0]  out_col;
        logic        last;
    } window_result_t;

    typedef struct {
        logic [1:0]  func;
        logic [12:0] widx;
        logic [15:0] value;
        bit          has_sum;   // typed-in expectation for kernel 0
        logic [39:0] sum;
    } stim_row_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    // predictor state
    logic [12:0]    cfg_shadow [8];
    logic [15:0]    weights [W_DEPTH];
    logic [15:0]    biases [MAX_KERNELS];
    logic [15:0]    lines [L_DEPTH];
    int unsigned    row_at, col_at, chan_at;
    window_result_t pending_sums [$];
    int             error_count;
    int             idle_pct;
    int             quiet_cycles;
    bit             hold_sink;
    bit             press_go;
    int unsigned    fmt_kr, fmt_kc, fmt_c, fmt_k;

    conv2d_valid_strided u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic int unsigned reg_value(input int i);
        int unsigned v;
        int unsigned mx [8];
        mx = '{MAX_WIDTH, MAX_HEIGHT, MAX_KROWS, MAX_KCOLS, MAX_CHANNELS, MAX_KERNELS,
               MAX_STRIDE, 1};
        v = cfg_shadow[i];
        if (i == REG_BIAS)
            return v & 1;
        if (v == 0)
            v = 1;
        if (v > mx[i])
            v = mx[i];
        return v;
    endfunction

    function automatic int unsigned line_addr(input int unsigned r, input int unsigned c,
                                              input int unsigned ch);
        return ((r % MAX_KROWS) * MAX_WIDTH + c) * MAX_CHANNELS + ch;
    endfunction

    // apply one accepted transaction; queue expected window sums
    task automatic predict_conv(input logic [1:0] func, input logic [12:0] widx,
                                input logic [15:0] value);
        int unsigned w, h, kr, kc, nc, nk, st, r, c, ch, top, left;
        longint acc, sat_hi, sat_lo;
        window_result_t res;
        w = reg_value(0); h = reg_value(1); kr = reg_value(2); kc = reg_value(3);
        nc = reg_value(4); nk = reg_value(5); st = reg_value(6);
        sat_hi = 64'sd549755813887;
        sat_lo = -sat_hi - 1;
        if (func == FUNC_WEIGHT)
        begin
            if (widx < W_DEPTH)
                weights[widx] = value;
            return;
        end
        if (func == FUNC_BIAS)
        begin
            if (widx < MAX_KERNELS)
                biases[widx] = value;
            return;
        end
        if (func != FUNC_PIXEL)
            return;
        r = row_at; c = col_at; ch = chan_at;
        if (r >= h || c >= w || ch >= nc)
        begin
            r = 0; c = 0; ch = 0;
        end
        lines[line_addr(r, c, ch)] = value;
        if (ch == nc - 1 && r + 1 >= kr && c + 1 >= kc)
        begin
            top = r + 1 - kr;
            left = c + 1 - kc;
            if (top % st == 0 && left % st == 0)
            begin
                for (int k = 0; k < nk; k++)
                begin
                    acc = 0;
                    for (int i = 0; i < kr; i++)
                        for (int j = 0; j < kc; j++)
                            for (int q = 0; q < nc; q++)
                                acc += longint'($signed(lines[line_addr(top + i, left + j, q)]))
                                     * longint'($signed(weights[((k * MAX_KROWS + i) * MAX_KCOLS
                                                                 + j) * MAX_CHANNELS + q]));
                    if (reg_value(REG_BIAS) != 0)
                        acc += longint'($signed(biases[k])) * 256;
                    if (acc > sat_hi)
                        acc = sat_hi;
                    if (acc < sat_lo)
                        acc = sat_lo;
                    res.sum_value = acc[39:0];
                    res.kernel_id = k[3:0];
                    res.out_row = 12'(top / st);
                    res.out_col = 8'(left / st);
                    res.last = (k == nk - 1);
                    pending_sums = {pending_sums, res};
                end
            end
        end
        ch++;
        if (ch >= nc)
        begin
            ch = 0;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
        end
        row_at = r; col_at = c; chan_at = ch;
    endtask

    // one transaction on the input stream, random gaps in front
    task automatic send_item(input logic [1:0] func, input logic [12:0] widx,
                             input logic [15:0] value);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = func;
        s_tdata = {3'b0, value, widx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_conv(func, widx, value);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [12:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_shadow[idx] = data & ((13'd1 << (idx == REG_WIDTH ? 9 : idx == REG_HEIGHT ? 13 :
                     idx == REG_CHANS ? 4 : idx == REG_KERNELS ? 5 : idx == REG_BIAS ? 1 : 3))
                     - 13'd1);
        if (idx != REG_BIAS)
        begin
            row_at = 0; col_at = 0; chan_at = 0;
        end
    endtask

    // drain, then let the block settle before touching registers
    task automatic wait_drained();
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    // load every weight and bias the current geometry reads
    task automatic load_params(input bit extreme);
        for (int k = 0; k < fmt_k; k++)
        begin
            send_item(FUNC_BIAS, 13'(k), 16'($urandom));
            for (int i = 0; i < fmt_kr; i++)
                for (int j = 0; j < fmt_kc; j++)
                    for (int q = 0; q < fmt_c; q++)
                        send_item(FUNC_WEIGHT,
                                  13'(((k * MAX_KROWS + i) * MAX_KCOLS + j) * MAX_CHANNELS + q),
                                  extreme ? 16'h8000 : 16'($urandom));
        end
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned kr,
                                input int unsigned kc, input int unsigned nc,
                                input int unsigned nk, input int unsigned st, input bit b);
        wait_drained();
        write_reg(REG_WIDTH, 13'(w));
        write_reg(REG_HEIGHT, 13'(h));
        write_reg(REG_KROWS, 13'(kr));
        write_reg(REG_KCOLS, 13'(kc));
        write_reg(REG_CHANS, 13'(nc));
        write_reg(REG_KERNELS, 13'(nk));
        write_reg(REG_STRIDE, 13'(st));
        write_reg(REG_BIAS, 13'(b));
        fmt_kr = reg_value(2); fmt_kc = reg_value(3);
        fmt_c = reg_value(4); fmt_k = reg_value(5);
    endtask

    // result checker
    always @(posedge clk)
    begin
        window_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[39:0], m_tdata[43:40], m_tdata[55:44], m_tdata[63:56], m_tlast};
            if (pending_sums.size() == 0)
                report_mismatch("unexpected result", m_tdata, 64'd0);
            else
            begin
                want = pending_sums.pop_front();
                if (got.sum_value !== want.sum_value)
                    report_mismatch("sum_value", got.sum_value, want.sum_value);
                if (got.kernel_id !== want.kernel_id)
                    report_mismatch("kernel_id", got.kernel_id, want.kernel_id);
                if (got.out_row !== want.out_row)
                    report_mismatch("out_row", got.out_row, want.out_row);
                if (got.out_col !== want.out_col)
                    report_mismatch("out_col", got.out_col, want.out_col);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_sink)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // long hold-off once the back-pressure phase starts
    initial
    begin
        hold_sink = 1'b0;
        wait (press_go);
        hold_sink = 1'b1;
        repeat (80)
            @(posedge clk);
        hold_sink = 1'b0;
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed [$];
        stim_row_t row;
        int unsigned first_kernel;
        error_count = 0;
        idle_pct = 0;
        press_go = 1'b0;
        row_at = 0; col_at = 0; chan_at = 0;
        cfg_shadow = '{13'd256, 13'd256, 13'd3, 13'd3, 13'd1, 13'd1, 13'd1, 13'd0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_WEIGHT;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: 1x1 kernel on a 2x2 image, extremes and ignored kinds
        set_geometry(2, 2, 1, 1, 1, 1, 1, 1);
        directed = '{
            '{FUNC_WEIGHT, 13'd0, 16'h8000, 1'b0, 40'd0},
            '{FUNC_BIAS, 13'd0, 16'h7FFF, 1'b0, 40'd0},
            '{FUNC_WEIGHT, 13'd8191, 16'h1234, 1'b0, 40'd0},  // past the store
            '{FUNC_BIAS, 13'd16, 16'h5555, 1'b0, 40'd0},      // past the store
            '{2'd3, 13'h1FFF, 16'hFFFF, 1'b0, 40'd0},          // unknown kind
            '{FUNC_PIXEL, 13'd0, 16'h8000, 1'b1, 40'h00407FFF00},
            '{FUNC_PIXEL, 13'h1FFF, 16'h7FFF, 1'b1, 40'hFFC0807F00},
            '{FUNC_PIXEL, 13'd0, 16'h0000, 1'b1, 40'h00007FFF00},
            '{FUNC_PIXEL, 13'd0, 16'hFFFF, 1'b1, 40'h0000807F00}
        };
        foreach (directed[n])
        begin
            row = directed[n];
            while (pending_sums.size() != 0)
                @(negedge clk);
            first_kernel = pending_sums.size();
            send_item(row.func, row.widx, row.value);
            if (row.has_sum && (pending_sums.size() != first_kernel + 1
                                || pending_sums[first_kernel].sum_value !== row.sum))
                report_mismatch("directed row", pending_sums.size(), row.sum);
        end

        // extremes: 3x3 kernel, all weights and samples at the minimum
        idle_pct = 33;
        set_geometry(3, 3, 3, 3, 1, 1, 1, 0);
        load_params(1'b1);
        for (int p = 0; p < 9; p++)
            send_item(FUNC_PIXEL, 13'($urandom), 16'h8000);

        // kernel larger than image: no window completes
        set_geometry(2, 1, 3, 3, 1, 1, 1, 0);
        for (int p = 0; p < 4; p++)
            send_item(FUNC_PIXEL, 13'($urandom), 16'($urandom));

        // zero and oversize register values clamp; all-ones fields
        set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
        load_params(1'b0);
        send_item(FUNC_PIXEL, 13'h1FFF, 16'hFFFF);
        set_geometry(511, 8191, 7, 7, 15, 31, 7, 1);
        set_geometry(9, 3, 2, 2, 1, 1, 7, 1);
        load_params(1'b0);
        for (int p = 0; p < 18; p++)
            send_item(FUNC_PIXEL, 13'($urandom), 16'($urandom));

        // tall single column: line store rows wrap past the slot count
        set_geometry(1, 12, 2, 1, 1, 1, 2, 1);
        load_params(1'b0);
        for (int p = 0; p < 12; p++)
            send_item(FUNC_PIXEL, 13'($urandom), 16'($urandom));

        // back pressure: no idling, receiver held off while samples keep coming
        idle_pct = 0;
        set_geometry(4, 3, 1, 1, 2, 2, 1, 0);
        load_params(1'b0);
        press_go = 1'b1;
        for (int p = 0; p < 12; p++)
            send_item(FUNC_PIXEL, 13'($urandom), 16'($urandom));

        // random phases: small frames, varied geometry, idling on both sides
        idle_pct = 33;
        for (int ph = 0; ph < 2; ph++)
        begin
            set_geometry($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 2),
                         $urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 2),
                         $urandom_range(1, 3), $urandom_range(0, 1));
            load_params(1'b0);
            for (int p = 0; p < 12; p++)
                if ($urandom_range(9) == 0)
                    send_item(2'($urandom_range(0, 3)), 13'($urandom), 16'($urandom));
                else
                    send_item(FUNC_PIXEL, 13'($urandom), 16'($urandom));
        end

        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (50)
            @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/cvs_pkg.sv
rtl/cvs_ram.sv
rtl/cvs_mac.sv
rtl/conv2d_valid_strided.sv
verif/testbench.sv
